@@ hdl/dll_pkg.sv @@
package dll_pkg;

	localparam int NODES  = 256;
	localparam int IDX_W  = $clog2(NODES);
	localparam int LINK_W = IDX_W + 1;

	typedef logic [LINK_W-1:0] link_t;

	localparam link_t NIL = LINK_W'(NODES);

	typedef enum logic [2:0] {
		K_PUSH_BACK  = 3'd0,
		K_PUSH_FRONT = 3'd1,
		K_POP_FRONT  = 3'd2,
		K_POP_BACK   = 3'd3,
		K_INS_BEFORE = 3'd4,
		K_INS_AFTER  = 3'd5,
		K_REMOVE     = 3'd6
	} kind_t;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	// one write to a link memory; addr may hold the null marker
	typedef struct packed {
		logic  en;
		link_t addr;
		link_t data;
	} link_wr_t;

	function automatic link_wr_t mk_wr(input logic en, input link_t addr, input link_t data);
		link_wr_t w;
		w.en   = en && !addr[IDX_W];
		w.addr = addr;
		w.data = data;
		return w;
	endfunction

endpackage

@@ hdl/dll_ram.sv @@
module dll_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/doubly_linked_list_manager.sv @@
// Doubly linked list manager over a pool of 256 node indices.
// Input channel (in_valid/in_ready): kind, node, anchor. Output channel
// (out_valid/out_ready): popped_node, status, is_empty, node_count, one
// result per operation, in order.
// Links live in two 256 x 9 memories (next and previous) with registered
// reads. An operation passes through the states S_IDLE, S_W1 and S_W2:
// S_IDLE accepts it and issues the link reads, S_W1 computes the new head,
// tail and count and makes the first write to each memory, and S_W2 makes
// the second write and loads the output register. The two writes per
// memory on a single write port mean that a new operation is accepted
// only once the previous one has left S_W2.
// If the output register still holds an untaken result, the block holds in
// S_W2 until the receiver takes it; no result is lost.
// Reset empties the list (head and tail null, count zero); the link memories
// are not cleared, as each entry is written before it is read.
// A pop on an empty list returns status 1 and changes nothing.
module doubly_linked_list_manager import dll_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       kind,
	input  logic [IDX_W-1:0] node,
	input  logic [IDX_W-1:0] anchor,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [IDX_W-1:0] popped_node,
	output logic             status,
	output logic             is_empty,
	output logic [LINK_W-1:0] node_count
);

	typedef enum logic [1:0] {S_IDLE, S_W1, S_W2} state_t;

	state_t            state_q;
	kind_t             kind_q;
	link_t             node_q, anchor_q;
	link_t             head_q, tail_q, len_q;
	link_wr_t          nw2_q, pw2_q;
	logic [IDX_W-1:0]  res_popped_q;
	logic              res_status_q;

	logic              out_valid_q;
	logic [IDX_W-1:0]  out_popped_q;
	logic              out_status_q, out_empty_q;
	link_t             out_count_q;

	logic [IDX_W-1:0]  nxt_raddr, prv_raddr;
	link_t             rn, rp, pop_prev;
	link_wr_t          nw1, pw1, nw2, pw2, nxt_wr, prv_wr;
	link_t             head_d, tail_d, len_d, len_up, len_dn;
	logic [IDX_W-1:0]  popped_d;
	logic              status_d;
	logic              in_xfer, out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// read addresses come from the input (pops use head or tail) so data lands in the next cycle
	always_comb begin
		case (kind_t'(kind))
			K_POP_FRONT: nxt_raddr = head_q[IDX_W-1:0];
			K_INS_AFTER: nxt_raddr = anchor;
			default:     nxt_raddr = node;
		endcase
		case (kind_t'(kind))
			K_POP_BACK:   prv_raddr = tail_q[IDX_W-1:0];
			K_INS_BEFORE: prv_raddr = anchor;
			default:      prv_raddr = node;
		endcase
	end

	// a null tail has no previous link
	assign pop_prev = (tail_q == NIL) ? NIL : rp;

	assign len_up = (len_q < NIL) ? len_q + 1'b1 : len_q;
	assign len_dn = (len_q != '0) ? len_q - 1'b1 : len_q;

	always_comb begin
		nw1      = '0;
		nw2      = '0;
		pw1      = '0;
		pw2      = '0;
		head_d   = head_q;
		tail_d   = tail_q;
		len_d    = len_q;
		popped_d = '0;
		status_d = STATUS_OK;
		case (kind_q)
			K_PUSH_BACK: begin
				nw1    = mk_wr(1'b1, node_q, NIL);
				pw1    = mk_wr(1'b1, node_q, tail_q);
				nw2    = mk_wr(tail_q != NIL, tail_q, node_q);
				head_d = (tail_q == NIL) ? node_q : head_q;
				tail_d = node_q;
				len_d  = len_up;
			end
			K_PUSH_FRONT: begin
				pw1    = mk_wr(1'b1, node_q, NIL);
				nw1    = mk_wr(1'b1, node_q, head_q);
				pw2    = mk_wr(head_q != NIL, head_q, node_q);
				tail_d = (head_q == NIL) ? node_q : tail_q;
				head_d = node_q;
				len_d  = len_up;
			end
			K_POP_FRONT: begin
				if (head_q == NIL) begin
					status_d = STATUS_EMPTY;
				end else begin
					popped_d = head_q[IDX_W-1:0];
					head_d   = rn;
					pw1      = mk_wr(rn != NIL, rn, NIL);
					tail_d   = (rn == NIL) ? NIL : tail_q;
					nw1      = mk_wr(1'b1, head_q, NIL);
					len_d    = len_dn;
				end
			end
			K_POP_BACK: begin
				if (head_q == NIL) begin
					status_d = STATUS_EMPTY;
				end else begin
					popped_d = tail_q[IDX_W-1:0];
					tail_d   = pop_prev;
					nw1      = mk_wr(pop_prev != NIL, pop_prev, NIL);
					head_d   = (pop_prev == NIL) ? NIL : head_q;
					pw1      = mk_wr(1'b1, tail_q, NIL);
					len_d    = len_dn;
				end
			end
			K_INS_BEFORE: begin
				pw1    = mk_wr(1'b1, node_q, rp);
				pw2    = mk_wr(1'b1, anchor_q, node_q);
				nw1    = mk_wr(1'b1, node_q, anchor_q);
				nw2    = mk_wr(rp != NIL, rp, node_q);
				head_d = (rp == NIL) ? node_q : head_q;
				len_d  = len_up;
			end
			K_INS_AFTER: begin
				nw1    = mk_wr(1'b1, node_q, rn);
				nw2    = mk_wr(1'b1, anchor_q, node_q);
				pw1    = mk_wr(1'b1, node_q, anchor_q);
				pw2    = mk_wr(rn != NIL, rn, node_q);
				tail_d = (rn == NIL) ? node_q : tail_q;
				len_d  = len_up;
			end
			K_REMOVE: begin
				nw1    = mk_wr(rp != NIL, rp, rn);
				head_d = (rp == NIL) ? rn : head_q;
				pw1    = mk_wr(rn != NIL, rn, rp);
				tail_d = (rn == NIL) ? rp : tail_q;
				nw2    = mk_wr(1'b1, node_q, NIL);
				pw2    = mk_wr(1'b1, node_q, NIL);
				len_d  = len_dn;
			end
			default: begin
			end
		endcase
	end

	// first writes come from the compute cycle, second writes from their registers
	always_comb begin
		case (state_q)
			S_W1: begin
				nxt_wr = nw1;
				prv_wr = pw1;
			end
			S_W2: begin
				nxt_wr = nw2_q;
				prv_wr = pw2_q;
			end
			default: begin
				nxt_wr = '0;
				prv_wr = '0;
			end
		endcase
	end

	dll_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_next_ram (
		.clk   (clk),
		.we    (nxt_wr.en),
		.waddr (nxt_wr.addr[IDX_W-1:0]),
		.wdata (nxt_wr.data),
		.raddr (nxt_raddr),
		.rdata (rn)
	);

	dll_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_prev_ram (
		.clk   (clk),
		.we    (prv_wr.en),
		.waddr (prv_wr.addr[IDX_W-1:0]),
		.wdata (prv_wr.data),
		.raddr (prv_raddr),
		.rdata (rp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= K_PUSH_BACK;
			node_q       <= '0;
			anchor_q     <= '0;
			head_q       <= NIL;
			tail_q       <= NIL;
			len_q        <= '0;
			nw2_q        <= '0;
			pw2_q        <= '0;
			res_popped_q <= '0;
			res_status_q <= STATUS_OK;
			out_valid_q  <= 1'b0;
			out_popped_q <= '0;
			out_status_q <= STATUS_OK;
			out_empty_q  <= 1'b1;
			out_count_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_W2) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						kind_q   <= kind_t'(kind);
						node_q   <= {1'b0, node};
						anchor_q <= {1'b0, anchor};
						state_q  <= S_W1;
					end
				end
				S_W1: begin
					head_q       <= head_d;
					tail_q       <= tail_d;
					len_q        <= len_d;
					nw2_q        <= nw2;
					pw2_q        <= pw2;
					res_popped_q <= popped_d;
					res_status_q <= status_d;
					state_q      <= S_W2;
				end
				S_W2: begin
					// hold here (rewriting the same entries) until the output register frees up
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_popped_q <= res_popped_q;
						out_status_q <= res_status_q;
						out_empty_q  <= (head_q == NIL);
						out_count_q  <= len_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign popped_node = out_popped_q;
	assign status      = out_status_q;
	assign is_empty    = out_empty_q;
	assign node_count  = out_count_q;

	a_wr_only_in_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		(nxt_wr.en || prv_wr.en) |-> (state_q == S_W1 || state_q == S_W2))
		else $error("link memory written outside a write cycle");

	a_accept_starts_compute: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == S_W1))
		else $error("accepted operation did not reach the compute cycle");

	a_empty_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == STATUS_EMPTY) |->
			(out_popped_q == '0 && out_empty_q))
		else $error("empty pop result carries a node or a non-empty list");

	a_result_waits_for_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_W2 && !out_free) |=> (state_q == S_W2 && $stable(res_popped_q)))
		else $error("result left the write cycle while the output register was full");

endmodule

@@ tb/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dll_pkg::*;

	// kind code outside the seven operations; the block must ignore it
	localparam logic [2:0] K_UNUSED = 3'd7;

	typedef struct packed {
		logic [IDX_W-1:0] popped;
		logic             status;
		logic             empty;
		link_t            count;
	} list_result_t;

	// Shadow copy of the list: predicts one result per operation and
	// keeps the outstanding results in order.
	class list_tracker;
		link_t            head_q;
		link_t            tail_q;
		link_t            count_q;
		link_t            next_lk [NODES];
		link_t            prev_lk [NODES];
		bit               written [NODES];
		list_result_t     owed_results[$];
		int               errors;
		logic [IDX_W-1:0] chain[$];
		logic [IDX_W-1:0] spare[$];
		logic [IDX_W-1:0] used[$];

		function new();
			head_q  = NIL;
			tail_q  = NIL;
			count_q = '0;
			errors  = 0;
			foreach (written[i]) written[i] = 1'b0;
		endfunction

		function void set_next(link_t i, link_t v);
			if (!i[IDX_W]) next_lk[i[IDX_W-1:0]] = v;
		endfunction

		function void set_prev(link_t i, link_t v);
			if (!i[IDX_W]) prev_lk[i[IDX_W-1:0]] = v;
		endfunction

		function void count_up();
			if (count_q < NIL) count_q++;
		endfunction

		function void count_down();
			if (count_q != '0) count_q--;
		endfunction

		function void apply_op(logic [2:0] k, logic [IDX_W-1:0] n, logic [IDX_W-1:0] a);
			list_result_t r;
			link_t        nl;
			link_t        al;
			link_t        t;
			link_t        q;
			r  = '0;
			nl = {1'b0, n};
			al = {1'b0, a};
			r.status = STATUS_OK;
			case (k)
			K_POP_FRONT, K_POP_BACK: begin
				if (head_q == NIL) begin
					r.status = STATUS_EMPTY;
				end else if (k == K_POP_FRONT) begin
					r.popped = head_q[IDX_W-1:0];
					head_q = next_lk[r.popped];
					if (head_q != NIL) set_prev(head_q, NIL);
					else tail_q = NIL;
					set_next({1'b0, r.popped}, NIL);
					count_down();
				end else begin
					// a null tail has no previous link
					t = tail_q;
					r.popped = t[IDX_W-1:0];
					tail_q = t[IDX_W] ? NIL : prev_lk[t[IDX_W-1:0]];
					if (tail_q != NIL) set_next(tail_q, NIL);
					else head_q = NIL;
					set_prev(t, NIL);
					count_down();
				end
			end
			K_PUSH_BACK: begin
				set_next(nl, NIL);
				set_prev(nl, tail_q);
				if (tail_q != NIL) set_next(tail_q, nl);
				else head_q = nl;
				tail_q = nl;
				count_up();
			end
			K_PUSH_FRONT: begin
				set_prev(nl, NIL);
				set_next(nl, head_q);
				if (head_q != NIL) set_prev(head_q, nl);
				else tail_q = nl;
				head_q = nl;
				count_up();
			end
			K_INS_BEFORE: begin
				t = prev_lk[a];
				set_prev(nl, t);
				set_next(nl, al);
				if (t != NIL) set_next(t, nl);
				else head_q = nl;
				set_prev(al, nl);
				count_up();
			end
			K_INS_AFTER: begin
				t = next_lk[a];
				set_next(nl, t);
				set_prev(nl, al);
				if (t != NIL) set_prev(t, nl);
				else tail_q = nl;
				set_next(al, nl);
				count_up();
			end
			K_REMOVE: begin
				t = prev_lk[n];
				q = next_lk[n];
				if (t != NIL) set_next(t, q);
				else head_q = q;
				if (q != NIL) set_prev(q, t);
				else tail_q = t;
				set_next(nl, NIL);
				set_prev(nl, NIL);
				count_down();
			end
			default: ;
			endcase
			// every insert or remove writes both links of its node
			if (k != K_POP_FRONT && k != K_POP_BACK && k != K_UNUSED) written[n] = 1'b1;
			r.empty = (head_q == NIL);
			r.count = count_q;
			owed_results.push_back(r);
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			if (owed_results.size() == 0) begin
				$error("result transfer with nothing outstanding");
				errors++;
				return;
			end
			want = owed_results.pop_front();
			if (got.popped !== want.popped) begin
				$error("popped_node: expected %0d, got %0d", want.popped, got.popped);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.empty !== want.empty) begin
				$error("is_empty: expected %0d, got %0d", want.empty, got.empty);
				errors++;
			end
			if (got.count !== want.count) begin
				$error("node_count: expected %0d, got %0d", want.count, got.count);
				errors++;
			end
		endfunction

		// Walk the list from the head; collect linked nodes, free nodes and
		// nodes whose links have been written. Stop on a loop left by misuse.
		function void survey();
			bit    on_chain [NODES];
			link_t cur;
			chain.delete();
			spare.delete();
			used.delete();
			foreach (on_chain[i]) on_chain[i] = 1'b0;
			cur = head_q;
			while (cur != NIL && !on_chain[cur[IDX_W-1:0]]) begin
				on_chain[cur[IDX_W-1:0]] = 1'b1;
				chain.push_back(cur[IDX_W-1:0]);
				cur = next_lk[cur[IDX_W-1:0]];
			end
			for (int i = 0; i < NODES; i++) begin
				if (!on_chain[i]) spare.push_back(IDX_W'(i));
				if (written[i]) used.push_back(IDX_W'(i));
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [2:0]       kind;
	logic [IDX_W-1:0] node;
	logic [IDX_W-1:0] anchor;
	logic             out_valid;
	logic             out_ready;
	logic [IDX_W-1:0] popped_node;
	logic             status;
	logic             is_empty;
	link_t            node_count;

	list_tracker sb;
	int          issued;
	int          taken;

	doubly_linked_list_manager u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.node        (node),
		.anchor      (anchor),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.popped_node (popped_node),
		.status      (status),
		.is_empty    (is_empty),
		.node_count  (node_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Called at a falling edge; returns at a falling edge after the transfer.
	task automatic send_op(input logic [2:0] k, input logic [IDX_W-1:0] n,
			input logic [IDX_W-1:0] a);
		bit steady;
		steady = (issued >= 300 && issued < 380);
		while (!steady && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		node     <= n;
		anchor   <= a;
		do @(posedge clk); while (!in_ready);
		sb.apply_op(k, n, a);
		issued++;
		@(negedge clk);
	endtask

	// grow: lean towards inserts, else towards pops and removes.
	// mixed: allow the odd step against the trend and stray operations.
	task automatic random_op(input bit grow, input bit mixed);
		logic [2:0]       k;
		logic [IDX_W-1:0] n;
		logic [IDX_W-1:0] a;
		bit               against;
		sb.survey();
		n = (sb.used.size() != 0) ? sb.used[$urandom_range(sb.used.size() - 1)] : '0;
		a = (sb.used.size() != 0) ? sb.used[$urandom_range(sb.used.size() - 1)] : '0;
		against = mixed && ($urandom_range(7) == 0);
		if (mixed && $urandom_range(15) == 0) begin
			// stray: any kind, free or linked nodes, anchors limited to written nodes
			k = 3'($urandom_range(7));
			if (sb.used.size() == 0 && k >= K_INS_BEFORE && k <= K_REMOVE) k = K_PUSH_BACK;
			if (k != K_REMOVE) n = IDX_W'($urandom);
			if (k != K_INS_BEFORE && k != K_INS_AFTER) a = IDX_W'($urandom);
		end else if (sb.chain.size() == 0) begin
			if (against) k = $urandom_range(1) ? K_POP_FRONT : K_POP_BACK;
			else k = $urandom_range(1) ? K_PUSH_FRONT : K_PUSH_BACK;
			n = sb.spare[$urandom_range(sb.spare.size() - 1)];
		end else if (sb.spare.size() != 0 && (grow ^ against)) begin
			case ($urandom_range(3))
			0: k = K_PUSH_BACK;
			1: k = K_PUSH_FRONT;
			2: k = K_INS_BEFORE;
			default: k = K_INS_AFTER;
			endcase
			n = sb.spare[$urandom_range(sb.spare.size() - 1)];
			a = sb.chain[$urandom_range(sb.chain.size() - 1)];
		end else begin
			case ($urandom_range(2))
			0: k = K_POP_FRONT;
			1: k = K_POP_BACK;
			default: k = K_REMOVE;
			endcase
			if (k == K_REMOVE) n = sb.chain[$urandom_range(sb.chain.size() - 1)];
		end
		send_op(k, n, a);
	endtask

	initial begin
		int target;
		int steps;
		int drain;
		sb = new();
		issued = 0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		kind     <= K_PUSH_BACK;
		node     <= '0;
		anchor   <= '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_op(K_POP_FRONT, 8'd0, 8'd0);
		send_op(K_POP_BACK, 8'd255, 8'd255);
		send_op(K_UNUSED, 8'd17, 8'd99);
		send_op(K_PUSH_BACK, 8'd0, 8'd0);
		send_op(K_PUSH_FRONT, 8'd255, 8'd0);
		send_op(K_INS_AFTER, 8'd128, 8'd0);
		send_op(K_INS_BEFORE, 8'd127, 8'd255);
		send_op(K_INS_AFTER, 8'd1, 8'd255);
		send_op(K_INS_BEFORE, 8'd254, 8'd0);
		send_op(K_REMOVE, 8'd128, 8'd0);
		send_op(K_REMOVE, 8'd127, 8'd0);
		send_op(K_REMOVE, 8'd1, 8'd0);
		send_op(K_POP_FRONT, 8'd0, 8'd0);
		send_op(K_POP_BACK, 8'd0, 8'd0);
		send_op(K_REMOVE, 8'd254, 8'd0);
		// removing a node that is no longer linked: count holds at zero
		send_op(K_REMOVE, 8'd254, 8'd0);
		send_op(K_PUSH_BACK, 8'h55, 8'h55);
		send_op(K_POP_BACK, 8'h55, 8'h55);
		send_op(K_PUSH_FRONT, 8'hAA, 8'h55);
		send_op(K_POP_FRONT, 8'hAA, 8'hAA);
		send_op(K_UNUSED, 8'hFF, 8'hFF);
		send_op(K_POP_FRONT, 8'hAA, 8'h55);

		// short lists built up and torn down again
		while (issued < 240) begin
			target = $urandom_range(1, 24);
			for (steps = 0; sb.count_q < target && steps < 4 * target; steps++)
				random_op(1'b1, 1'b1);
			for (steps = 0; sb.count_q != 0 && steps < 4 * target; steps++)
				random_op(1'b0, 1'b1);
		end

		// fill the whole pool, overfill once, then drain
		for (steps = 0; sb.count_q < NODES && steps < 300; steps++)
			random_op(1'b1, 1'b0);
		if (sb.count_q == NODES) begin
			sb.survey();
			send_op(K_PUSH_BACK, sb.chain[$urandom_range(sb.chain.size() - 1)], 8'd0);
		end
		while (sb.count_q != 0 && issued < 560)
			random_op(1'b0, 1'b1);

		in_valid <= 1'b0;
		for (drain = 0; sb.owed_results.size() != 0 && drain < 5000; drain++)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.owed_results.size() != 0) begin
			$error("%0d results never arrived", sb.owed_results.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("doubly_linked_list_manager verification clean");
		end else begin
			$display("doubly_linked_list_manager verification failed");
		end
		$finish;
	end

	initial begin
		bit held;
		held = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (taken == 60 && !held) begin
				// hold off long enough for the block to back up into its input
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (200) @(negedge clk);
			end
			out_ready <= (taken >= 300 && taken < 380) || ($urandom_range(99) >= 34);
		end
	end

	initial taken = 0;

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_result('{popped: popped_node, status: status, empty: is_empty,
				count: node_count});
			taken++;
		end
	end

	initial begin
		#2_000_000;
		$display("doubly_linked_list_manager verification failed");
		$finish;
	end

endmodule
